// File: sv/json_byte_tokenizer_defines.svh
// Assertion macros shared by the JSON byte tokenizer RTL.
// Define ASSERT_OFF to compile every check out; no other dependencies.
`ifndef JSON_BYTE_TOKENIZER_DEFINES_SVH
`define JSON_BYTE_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, masked while reset is asserted
`define JBT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds during reset
`define JBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JBT_ASSERT(lbl, clk, rstn, prop, msg)
`define JBT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/jbt_pkg.sv
// Types, codes and keyword tables for the JSON byte tokenizer.
// No dependencies; imported by json_byte_tokenizer.
package jbt_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int OUT_DATA_BITS   = 72;
	localparam int FIFO_DEPTH      = 4;

	// input item kinds
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_END  = 1'b1;

	typedef enum logic [3:0] {
		TOK_END      = 4'd0,
		TOK_LBRACE   = 4'd1,
		TOK_RBRACE   = 4'd2,
		TOK_LBRACKET = 4'd3,
		TOK_RBRACKET = 4'd4,
		TOK_COLON    = 4'd5,
		TOK_COMMA    = 4'd6,
		TOK_STRING   = 4'd7,
		TOK_NUMBER   = 4'd8,
		TOK_TRUE     = 4'd9,
		TOK_FALSE    = 4'd10,
		TOK_NULL     = 4'd11
	} tok_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_UNTERM    = 2'd2,
		ST_TOO_LONG  = 2'd3
	} tok_status_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_STR     = 3'd1,
		MODE_ESC     = 3'd2,
		MODE_SIGN    = 3'd3,
		MODE_DIG     = 3'd4,
		MODE_KW      = 3'd5,
		MODE_DISCARD = 3'd6
	} lex_mode_t;

	// keyword selector
	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	typedef struct packed {
		tok_kind_t          kind;
		tok_status_t        status;
		logic [15:0]        string_start;
		logic [15:0]        string_length;
		logic signed [31:0] number_value;
		logic               last;
	} jbt_result_t;

	// letters in each keyword
	function automatic logic [2:0] kw_len(input logic [1:0] sel);
		logic [2:0] len;
		case (sel)
			KW_TRUE:  len = 3'd4;
			KW_FALSE: len = 3'd5;
			KW_NULL:  len = 3'd4;
			default:  len = 3'd0;
		endcase
		return len;
	endfunction

	// letter idx of keyword sel
	function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		case (sel)
			KW_TRUE: begin
				case (idx)
					3'd0:    ch = "t";
					3'd1:    ch = "r";
					3'd2:    ch = "u";
					3'd3:    ch = "e";
					default: ch = 8'h00;
				endcase
			end
			KW_FALSE: begin
				case (idx)
					3'd0:    ch = "f";
					3'd1:    ch = "a";
					3'd2:    ch = "l";
					3'd3:    ch = "s";
					3'd4:    ch = "e";
					default: ch = 8'h00;
				endcase
			end
			KW_NULL: begin
				case (idx)
					3'd0:    ch = "n";
					3'd1:    ch = "u";
					3'd2:    ch = "l";
					3'd3:    ch = "l";
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic tok_kind_t kw_kind(input logic [1:0] sel);
		tok_kind_t k;
		case (sel)
			KW_TRUE:  k = TOK_TRUE;
			KW_FALSE: k = TOK_FALSE;
			default:  k = TOK_NULL;
		endcase
		return k;
	endfunction

endpackage

// File: sv/json_byte_tokenizer.sv
// Streaming JSON lexer, top level: input register, one lexing stage, result queue.
// Depends on jbt_pkg and json_byte_tokenizer_defines.svh.
//
// One input transfer per clock while not stalled: a data byte (tuser 0) or an end-of-buffer
// mark (tuser 1). Each item is registered, then lexed against the offset, mode, keyword,
// number and string registers; its results (none, one or two) enter a four-entry result
// queue, from which they are offered on the output. While m_axis_tready is high the output
// side drains one result per cycle, which sets the sustained rate: one item per cycle while
// items give at most one result each, and one more output transfer for each item that gives
// two (a byte that ends a number and then makes its own token or error, or an end mark after
// a pending token). The input stalls only while fewer than two queue entries are free.
`include "json_byte_tokenizer_defines.svh"

module json_byte_tokenizer
	import jbt_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [7:0]               s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]               s_axis_tuser,  // [0] req_type
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// [1:0] status, [17:2] string_start, [33:18] string_length,
	// [65:34] number_value, [71:66] zero
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	output logic [3:0]               m_axis_tuser,  // [3:0] token_kind
	output logic                     m_axis_tlast   // last_of_run
);

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] OFFSET_ONE = OFFSET_BITS'(1);
	localparam logic [7:0]             CH_CR      = 8'h0D;

	// input stage
	logic       s1_valid_q;
	logic       s1_req_q;
	logic [7:0] s1_byte_q;
	logic       s1_adv;

	// lexer state
	logic [OFFSET_BITS-1:0] offset_q, offset_n;
	lex_mode_t              mode_q, mode_n;
	logic [1:0]             kw_sel_q, kw_sel_n;
	logic [2:0]             kw_idx_q, kw_idx_n;
	logic [31:0]            acc_q, acc_n;
	logic                   neg_q, neg_n;
	logic [15:0]            hstart_q, hstart_n;
	logic [15:0]            hlen_q, hlen_n;

	// result queue
	jbt_result_t fifo_q [FIFO_DEPTH];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  count_q;
	logic        pop;

	// lexing results of the current item
	logic        e0_v, e1_v;
	tok_kind_t   e0_k, e1_k;
	tok_status_t e0_s, e1_s;
	logic [1:0]  push_n;
	jbt_result_t res0, res1;

	// combinational helpers
	logic [7:0]             b;
	logic                   is_digit;
	logic [OFFSET_BITS-1:0] off_inc;
	logic [OFFSET_BITS+15:0] off_inc_ext;
	logic                   do_idle;
	logic                   idl_emit;
	tok_kind_t              idl_kind;
	tok_status_t            idl_stat;
	logic                   kw_match;
	logic [31:0]            acc_x10;
	logic [15:0]            hlen_inc;

	// check helpers
	logic                   end_adv;
	logic                   data_adv;
	logic                   in_discard;

	// input register stage: advances once the queue can take two results
	assign s1_adv        = s1_valid_q && (count_q <= 3'(FIFO_DEPTH - 2));
	assign s_axis_tready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			s1_req_q  <= s_axis_tuser[0];
			s1_byte_q <= s_axis_tdata;
		end
	end

	// byte decode shared by the lexing paths
	assign b           = s1_byte_q;
	assign is_digit    = b inside {["0":"9"]};
	assign off_inc     = offset_q + OFFSET_ONE;
	assign off_inc_ext = {16'h0000, off_inc};
	assign acc_x10     = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'h0, b[3:0]};
	assign hlen_inc    = (hlen_q != 16'hFFFF) ? hlen_q + 16'd1 : hlen_q;
	assign kw_match    = (kw_idx_q < kw_len(kw_sel_q)) && (b == kw_char(kw_sel_q, kw_idx_q));

	// next state and results for the item in the input stage
	always_comb begin
		offset_n = offset_q;
		mode_n   = mode_q;
		kw_sel_n = kw_sel_q;
		kw_idx_n = kw_idx_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		hstart_n = hstart_q;
		hlen_n   = hlen_q;
		e0_v     = 1'b0;
		e0_k     = TOK_END;
		e0_s     = ST_OK;
		e1_v     = 1'b0;
		e1_k     = TOK_END;
		e1_s     = ST_OK;
		do_idle  = 1'b0;
		idl_emit = 1'b0;
		idl_kind = TOK_END;
		idl_stat = ST_OK;

		if (s1_req_q == REQ_DATA) begin
			if (mode_q == MODE_DISCARD || !(mode_q inside {MODE_IDLE, MODE_STR, MODE_ESC,
					MODE_SIGN, MODE_DIG, MODE_KW})) begin
				mode_n = MODE_DISCARD;
			end else if (offset_q == OFFSET_MAX) begin
				e0_v   = 1'b1;
				e0_s   = ST_TOO_LONG;
				mode_n = MODE_DISCARD;
			end else begin
				case (mode_q)
					MODE_IDLE: begin
						do_idle = 1'b1;
					end
					MODE_STR: begin
						if (b == "\"") begin
							e0_v   = 1'b1;
							e0_k   = TOK_STRING;
							mode_n = MODE_IDLE;
						end else begin
							hlen_n = hlen_inc;
							if (b == "\\") begin
								mode_n = MODE_ESC;
							end
						end
					end
					MODE_ESC: begin
						hlen_n = hlen_inc;
						mode_n = MODE_STR;
					end
					MODE_SIGN, MODE_DIG: begin
						if (is_digit) begin
							acc_n  = acc_x10;
							mode_n = MODE_DIG;
						end else if (mode_q == MODE_SIGN) begin
							e0_v   = 1'b1;
							e0_s   = ST_MALFORMED;
							mode_n = MODE_DISCARD;
						end else begin
							// number ends; the byte is lexed again from idle
							e0_v    = 1'b1;
							e0_k    = TOK_NUMBER;
							mode_n  = MODE_IDLE;
							do_idle = 1'b1;
						end
					end
					MODE_KW: begin
						if (kw_match) begin
							kw_idx_n = kw_idx_q + 3'd1;
							if (kw_idx_q + 3'd1 == kw_len(kw_sel_q)) begin
								e0_v   = 1'b1;
								e0_k   = kw_kind(kw_sel_q);
								mode_n = MODE_IDLE;
							end
						end else begin
							e0_v   = 1'b1;
							e0_s   = ST_MALFORMED;
							mode_n = MODE_DISCARD;
						end
					end
					default: begin
						mode_n = MODE_DISCARD;
					end
				endcase
			end

			// idle-mode lexing of the byte
			if (do_idle) begin
				case (b)
					"{": begin idl_emit = 1'b1; idl_kind = TOK_LBRACE;   end
					"}": begin idl_emit = 1'b1; idl_kind = TOK_RBRACE;   end
					"[": begin idl_emit = 1'b1; idl_kind = TOK_LBRACKET; end
					"]": begin idl_emit = 1'b1; idl_kind = TOK_RBRACKET; end
					":": begin idl_emit = 1'b1; idl_kind = TOK_COLON;    end
					",": begin idl_emit = 1'b1; idl_kind = TOK_COMMA;    end
					" ", "\t", CH_CR, "\n": begin
					end
					"\"": begin
						hstart_n = off_inc_ext[15:0];
						hlen_n   = 16'd0;
						mode_n   = MODE_STR;
					end
					"t", "f", "n": begin
						kw_sel_n = (b == "t") ? KW_TRUE : ((b == "f") ? KW_FALSE : KW_NULL);
						kw_idx_n = 3'd1;
						mode_n   = MODE_KW;
					end
					"-": begin
						acc_n  = 32'd0;
						neg_n  = 1'b1;
						mode_n = MODE_SIGN;
					end
					default: begin
						if (is_digit) begin
							acc_n  = {28'h0, b[3:0]};
							neg_n  = 1'b0;
							mode_n = MODE_DIG;
						end else begin
							idl_emit = 1'b1;
							idl_stat = ST_MALFORMED;
							mode_n   = MODE_DISCARD;
						end
					end
				endcase
				if (idl_emit) begin
					if (e0_v) begin
						e1_v = 1'b1;
						e1_k = idl_kind;
						e1_s = idl_stat;
					end else begin
						e0_v = 1'b1;
						e0_k = idl_kind;
						e0_s = idl_stat;
					end
				end
			end

			if (offset_q != OFFSET_MAX) begin
				offset_n = off_inc;
			end
		end else begin
			// end of buffer: close any pending token, then the end token
			case (mode_q)
				MODE_STR: begin
					e0_v = 1'b1;
					e0_s = ST_UNTERM;
				end
				MODE_ESC, MODE_SIGN, MODE_KW: begin
					e0_v = 1'b1;
					e0_s = ST_MALFORMED;
				end
				MODE_DIG: begin
					e0_v = 1'b1;
					e0_k = TOK_NUMBER;
				end
				default: begin
				end
			endcase
			if (e0_v) begin
				e1_v = 1'b1;
			end else begin
				e0_v = 1'b1;
			end
			offset_n = '0;
			mode_n   = MODE_IDLE;
			kw_sel_n = 2'd0;
			kw_idx_n = 3'd0;
		end
	end

	// result records; values are those held before this item
	always_comb begin
		res0.kind          = e0_k;
		res0.status        = e0_s;
		res0.string_start  = hstart_q;
		res0.string_length = hlen_q;
		res0.number_value  = neg_q ? (32'd0 - acc_q) : acc_q;
		res0.last          = !e1_v;
		res1               = res0;
		res1.kind          = e1_k;
		res1.status        = e1_s;
		res1.last          = 1'b1;
	end

	assign push_n = s1_adv ? ({1'b0, e0_v} + {1'b0, e1_v}) : 2'd0;

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			mode_q   <= MODE_IDLE;
			kw_sel_q <= 2'd0;
			kw_idx_q <= 3'd0;
			acc_q    <= 32'd0;
			neg_q    <= 1'b0;
			hstart_q <= 16'd0;
			hlen_q   <= 16'd0;
		end else if (s1_adv) begin
			offset_q <= offset_n;
			mode_q   <= mode_n;
			kw_sel_q <= kw_sel_n;
			kw_idx_q <= kw_idx_n;
			acc_q    <= acc_n;
			neg_q    <= neg_n;
			hstart_q <= hstart_n;
			hlen_q   <= hlen_n;
		end
	end

	// result queue pointers
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	// output transfer
	assign m_axis_tvalid = (count_q != 3'd0);
	assign m_axis_tuser  = fifo_q[rd_ptr_q].kind;
	assign m_axis_tlast  = fifo_q[rd_ptr_q].last;
	assign m_axis_tdata  = {6'b000000,
		fifo_q[rd_ptr_q].number_value,
		fifo_q[rd_ptr_q].string_length,
		fifo_q[rd_ptr_q].string_start,
		fifo_q[rd_ptr_q].status};

	// checks
	assign end_adv    = s1_adv && (s1_req_q == REQ_END);
	assign data_adv   = s1_adv && (s1_req_q == REQ_DATA);
	assign in_discard = (mode_q == MODE_DISCARD);

	`JBT_ASSERT(a_fifo_bound, clk, arst_n, count_q <= 3'(FIFO_DEPTH), "result queue overflow")
	`JBT_ASSERT(a_end_resets, clk, arst_n, end_adv |=> (in_discard == 1'b0 && mode_q == MODE_IDLE && offset_q == '0), "no reset at end")
	`JBT_ASSERT(a_discard_sticky, clk, arst_n, (in_discard && !end_adv) |=> in_discard, "discard left early")
	`JBT_ASSERT(a_offset_sat, clk, arst_n, (data_adv && offset_q == OFFSET_MAX) |=> (offset_q == OFFSET_MAX), "offset moved")

endmodule
